/* hw/rtl/sstk_pkg.sv */
// ----------------------------------------------------------------------------
// sstk_pkg - shared types for the top-k sorter
// Record entry held in each chain cell, and the command that steers the chain.
// ----------------------------------------------------------------------------
package sstk_pkg;

    localparam int TAG_W        = 16;
    localparam int SCORE_W      = 8;
    localparam int TOTAL_W      = 10;
    localparam int SEL_W        = 7;
    localparam int MAX_RECORDS_DEF = 64;
    localparam logic [SEL_W-1:0] SEL_RESET = 7'd64;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TOTAL_W-1:0] total;
    } entry_t;

    // hold: keep contents; insert: sorted insertion of the broadcast record;
    // shift: move toward the head by one; clear: drop all contents
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SHIFT  = 2'd2,
        CMD_CLEAR  = 2'd3
    } chain_cmd_t;

endpackage

/* hw/rtl/score_sort_top_k_with_ties_unit.sv */
// ----------------------------------------------------------------------------
// score_sort_top_k_with_ties_unit - streaming top-k sorter with tie extension
// Sums three scores per record, keeps records in a stable descending chain,
// and on the final record streams out the top select_count plus the ties.
// ----------------------------------------------------------------------------
// Throughput: one record per cycle while loading; the cell chain inserts in
//   the cycle of the transfer. Emission streams one result per cycle from the
//   chain head while m_tready holds high, and s_tready stays low meanwhile.
// Sequencing: the final record's transfer enters the emit state, which
//   registers the results; loading resumes at the edge that registers the
//   last result. An empty run clears the chain and returns to loading.
// Reset: synchronous, active low; empties the chain, sets select_count to 64.
// ----------------------------------------------------------------------------
module score_sort_top_k_with_ties_unit
    import sstk_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    // config write: select_count
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [SEL_W-1:0] cfg_data,
    // input records
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // record_tag[15:0], score_a[23:16],
                                        // score_b[31:24], score_c[39:32]
    input  logic             s_tlast,   // final_record
    // results
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,   // out_tag[15:0], total[25:16], zero pad
    output logic             m_tuser,   // extra_list
    output logic             m_tlast    // run_end
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int LW    = (CNT_W > SEL_W) ? CNT_W : SEL_W;

    typedef enum logic {ST_LOAD, ST_EMIT} state_t;

    state_t           state_reg, state_next;
    logic [SEL_W-1:0] select_reg, select_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [TOTAL_W-1:0] tie_reg, tie_next;
    logic             m_valid_reg, m_valid_next;
    entry_t           m_entry_reg, m_entry_next;
    logic             m_extra_reg, m_extra_next;
    logic             m_last_reg, m_last_next;

    chain_cmd_t       cmd;
    entry_t           new_entry;
    entry_t           cell_entry [MAX_RECORDS];
    logic             cell_valid [MAX_RECORDS];
    logic             cell_keep  [MAX_RECORDS];

    logic             s_xfer;
    logic             emit_slot;
    logic [LW-1:0]    limit;
    logic [LW-1:0]    idx_ext;
    logic [LW-1:0]    idx_inc;
    logic [LW-1:0]    count_ext;
    logic [TOTAL_W-1:0] tie_cur;
    logic             more;

    // Form the record total from the three scores.
    assign new_entry.tag   = s_tdata[15:0];
    assign new_entry.total = TOTAL_W'(s_tdata[23:16]) + TOTAL_W'(s_tdata[31:24])
                           + TOTAL_W'(s_tdata[39:32]);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_LOAD);
    assign s_xfer    = s_tvalid && s_tready;

    // Main-list length: select_count clamped to the records held.
    assign count_ext = LW'(count_reg);
    assign idx_ext   = LW'(idx_reg);
    assign idx_inc   = idx_ext + LW'(1);
    assign limit     = (LW'(select_reg) < count_ext) ? LW'(select_reg) : count_ext;

    // Output register free or draining this cycle.
    assign emit_slot = !m_valid_reg || m_tready;

    // Tie total is the last main-list record; it is the head when idx hits it.
    assign tie_cur = (idx_inc == limit) ? cell_entry[0].total : tie_reg;
    // Another record follows: main list continues, or the next one ties.
    assign more = (idx_inc < limit)
               || ((idx_inc < count_ext) && (cell_entry[1].total == tie_cur));

    always_comb begin
        state_next   = state_reg;
        select_next  = select_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        tie_next     = tie_reg;
        m_valid_next = m_valid_reg;
        m_entry_next = m_entry_reg;
        m_extra_next = m_extra_reg;
        m_last_next  = m_last_reg;
        cmd          = CMD_HOLD;

        if (cfg_valid && cfg_ready) begin
            select_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    // drop records past capacity
                    if (count_reg < CNT_W'(MAX_RECORDS)) begin
                        cmd        = CMD_INSERT;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (limit == '0) begin
                    cmd        = CMD_CLEAR;
                    count_next = '0;
                    state_next = ST_LOAD;
                end else if (emit_slot) begin
                    m_valid_next = 1'b1;
                    m_entry_next = cell_entry[0];
                    m_extra_next = !(idx_ext < limit);
                    m_last_next  = !more;
                    tie_next     = tie_cur;
                    idx_next     = idx_reg + CNT_W'(1);
                    if (more) begin
                        cmd = CMD_SHIFT;
                    end else begin
                        cmd        = CMD_CLEAR;
                        count_next = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        m_entry_reg <= m_entry_next;
        m_extra_reg <= m_extra_next;
        m_last_reg  <= m_last_next;
        tie_reg     <= tie_next;
        idx_reg     <= idx_next;
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            select_reg  <= SEL_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            select_reg  <= select_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Insertion chain: cell 0 is the head (highest total).
    genvar gi;
    generate
        for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
            entry_t prev_e;
            logic   prev_v;
            logic   prev_k;
            entry_t next_e;
            logic   next_v;

            if (gi == 0) begin : g_head
                assign prev_e = new_entry;
                assign prev_v = 1'b0;
                assign prev_k = 1'b1;
            end else begin : g_body
                assign prev_e = cell_entry[gi-1];
                assign prev_v = cell_valid[gi-1];
                assign prev_k = cell_keep[gi-1];
            end

            if (gi == MAX_RECORDS - 1) begin : g_tail
                assign next_e = new_entry;
                assign next_v = 1'b0;
            end else begin : g_mid
                assign next_e = cell_entry[gi+1];
                assign next_v = cell_valid[gi+1];
            end

            sstk_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_valid (prev_v),
                .prev_keep  (prev_k),
                .next_entry (next_e),
                .next_valid (next_v),
                .cell_entry (cell_entry[gi]),
                .cell_valid (cell_valid[gi]),
                .cell_keep  (cell_keep[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_entry_reg.total, m_entry_reg.tag};
    assign m_tuser  = m_extra_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* hw/rtl/sstk_cell.sv */
// ----------------------------------------------------------------------------
// sstk_cell - one cell of the insertion chain
// Holds one record; on insert it keeps, takes the new record or takes the
// neighbor ahead of it (toward the head); on shift it takes the neighbor behind it.
// ----------------------------------------------------------------------------
module sstk_cell
    import sstk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chain_cmd_t cmd,
    input  entry_t     new_entry,
    input  entry_t     prev_entry,
    input  logic       prev_valid,
    input  logic       prev_keep,
    input  entry_t     next_entry,
    input  logic       next_valid,
    output entry_t     cell_entry,
    output logic       cell_valid,
    output logic       cell_keep
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    // Stay put when the stored total ranks at or above the newcomer.
    assign cell_keep = valid_reg && (entry_reg.total >= new_entry.total);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_INSERT: begin
                if (!cell_keep) begin
                    if (prev_keep) begin
                        entry_next = new_entry;
                        valid_next = 1'b1;
                    end else begin
                        entry_next = prev_entry;
                        valid_next = prev_valid;
                    end
                end
            end
            CMD_SHIFT: begin
                entry_next = next_entry;
                valid_next = next_valid;
            end
            CMD_CLEAR: valid_next = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign cell_entry = entry_reg;
    assign cell_valid = valid_reg;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - top-k score sorter with tie extension
// Streams record sets into the sorter and predicts every ranked result
// (stable descending order by total, top select_count, then the tied tail).
// Each result transfer is checked field by field against the oldest
// prediction. Both stream sides idle at random, and one phase holds the
// result side off for a long stretch while records keep being offered.
// ----------------------------------------------------------------------------
module testbench;
    import sstk_pkg::*;

    localparam int STORE_DEPTH   = MAX_RECORDS_DEF;
    localparam int ITEM_TARGET   = 330;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transfer on any port
    localparam int LONG_HOLD     = 150;   // receiver hold-off in the pressure phase
    localparam int SETTLE_CYCLES = 8;     // covers the turnaround of a run
    localparam int TAIL_ITEMS    = 40;    // last items run without idling

    // One input record and one ranked result, at the block's field widths
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score_a;
        logic [SCORE_W-1:0] score_b;
        logic [SCORE_W-1:0] score_c;
        logic               final_record;
    } record_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TOTAL_W-1:0] total;
        logic               extra_list;
        logic               run_end;
    } ranked_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [SEL_W-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;  // record_tag[15:0], score_a[23:16],
                                       // score_b[31:24], score_c[39:32]
    logic             s_tlast   = 1'b0; // final_record
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;          // out_tag[15:0], total[25:16], zero pad
    logic             m_tuser;          // extra_list
    logic             m_tlast;          // run_end

    // Stimulus and prediction state
    record_t          pending_records[$];
    ranked_t          expected_ranking[$];
    entry_t           ranked_store[STORE_DEPTH];
    int               ranked_count   = 0;
    logic [SEL_W-1:0] select_shadow  = SEL_RESET;
    record_t          driven_record;
    int               queued_n       = 0;
    int               accepted_n     = 0;
    int               mismatch_count = 0;
    int               tx_gap         = 0;
    int               rx_gap         = 0;
    int               long_hold      = 0;
    bit               calm_tail      = 1'b0;
    bit               stimulus_done  = 1'b0;

    score_sort_top_k_with_ties_unit #(
        .MAX_RECORDS(STORE_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Ranking predictor: insert one accepted record into the shadow store and,
    // on the final record, queue the whole emitted run.
    // ------------------------------------------------------------------------
    function automatic void rank_record(input record_t rec);
        logic [TOTAL_W-1:0] sum;
        logic [TOTAL_W-1:0] tie_total;
        int                 pos;
        int                 k;
        int                 limit;
        int                 idx;
        ranked_t            run[$];
        ranked_t            item;

        sum = TOTAL_W'(rec.score_a) + TOTAL_W'(rec.score_b) + TOTAL_W'(rec.score_c);

        // Drop the record when the store is full; a final flag still counts
        if (ranked_count < STORE_DEPTH) begin
            // Place after every entry with an equal or greater total (stable)
            pos = 0;
            while (pos < ranked_count && ranked_store[pos].total >= sum)
                pos++;
            for (k = ranked_count; k > pos; k--)
                ranked_store[k] = ranked_store[k-1];
            ranked_store[pos].tag   = rec.tag;
            ranked_store[pos].total = sum;
            ranked_count++;
        end

        if (!rec.final_record)
            return;

        // Clamp the main list to the records actually held
        limit = (int'(select_shadow) > ranked_count) ? ranked_count
                                                     : int'(select_shadow);
        for (idx = 0; idx < limit; idx++) begin
            item.tag        = ranked_store[idx].tag;
            item.total      = ranked_store[idx].total;
            item.extra_list = 1'b0;
            item.run_end    = 1'b0;
            run.push_back(item);
        end

        // Extend with the tied tail, stopping at the end of the held entries
        if (limit > 0) begin
            tie_total = ranked_store[limit-1].total;
            while (idx < ranked_count && ranked_store[idx].total == tie_total) begin
                item.tag        = ranked_store[idx].tag;
                item.total      = ranked_store[idx].total;
                item.extra_list = 1'b1;
                item.run_end    = 1'b0;
                run.push_back(item);
                idx++;
            end
        end

        // Mark the last result of the run
        if (run.size() > 0) begin
            item = run.pop_back();
            item.run_end = 1'b1;
            run.push_back(item);
        end

        foreach (run[i])
            expected_ranking.push_back(run[i]);
        ranked_count = 0;
    endfunction

    // ------------------------------------------------------------------------
    // Record driver: predict on each input transfer, then load the next
    // pending record or insert a short gap.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // Track select_count writes in the shadow configuration
            if (cfg_valid && cfg_ready)
                select_shadow = cfg_data;

            if (s_tvalid && s_tready) begin
                rank_record(driven_record);
                accepted_n++;
            end

            // Advance only when the output slot is empty or just transferred
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_records.size() > 0) begin
                    driven_record = pending_records.pop_front();
                    s_tdata  <= {driven_record.score_c, driven_record.score_b,
                                 driven_record.score_a, driven_record.tag};
                    s_tlast  <= driven_record.final_record;
                    s_tvalid <= 1'b1;
                    if (!calm_tail && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each result transfer against the oldest
    // prediction, then choose the next tready (long hold, burst, or ready).
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        ranked_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_ranking.size() == 0) begin
                    $display("%0t: result with nothing expected: tag %h total %0d",
                             $time, m_tdata[15:0], m_tdata[25:16]);
                    mismatch_count++;
                end else begin
                    want = expected_ranking.pop_front();
                    if (m_tdata[15:0] !== want.tag) begin
                        $display("%0t: out_tag expected %h actual %h",
                                 $time, want.tag, m_tdata[15:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[25:16] !== want.total) begin
                        $display("%0t: total expected %0d actual %0d",
                                 $time, want.total, m_tdata[25:16]);
                        mismatch_count++;
                    end
                    if (m_tuser !== want.extra_list) begin
                        $display("%0t: extra_list expected %b actual %b",
                                 $time, want.extra_list, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tlast !== want.run_end) begin
                        $display("%0t: run_end expected %b actual %b",
                                 $time, want.run_end, m_tlast);
                        mismatch_count++;
                    end
                end
            end

            // Hold off for the requested stretch first, then random bursts
            if (long_hold > 0) begin
                long_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 5) == 0)
                    rx_gap = $urandom_range(1, 4);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no port has transferred for too long.
    // ------------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (!stimulus_done && quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        if (!stimulus_done) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Queue one record for the driver
    task automatic add_record(input logic [TAG_W-1:0] tag, input logic [SCORE_W-1:0] sa,
                              input logic [SCORE_W-1:0] sb, input logic [SCORE_W-1:0] sc,
                              input logic fin);
        record_t rec;
        rec.tag          = tag;
        rec.score_a      = sa;
        rec.score_b      = sb;
        rec.score_c      = sc;
        rec.final_record = fin;
        pending_records.push_back(rec);
        queued_n++;
    endtask

    // Queue a set of random records; tie-heavy sets draw scores from a few
    // values so that many totals collide
    task automatic add_random_set(input int count, input bit tie_heavy);
        logic [SCORE_W-1:0] sc[3];
        for (int i = 0; i < count; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (tie_heavy) begin
                    case ($urandom_range(0, 3))
                        0:       sc[j] = 8'h00;
                        1:       sc[j] = 8'h01;
                        2:       sc[j] = 8'h80;
                        default: sc[j] = 8'hFF;
                    endcase
                end else begin
                    sc[j] = SCORE_W'($urandom_range(0, 255));
                end
            end
            add_record(TAG_W'($urandom_range(0, 16'hFFFF)), sc[0], sc[1], sc[2],
                       i == count - 1);
        end
    endtask

    // Wait until every record is accepted and every result has arrived,
    // then let the block return to loading
    task automatic settle();
        while (accepted_n != queued_n || expected_ranking.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write select_count; call only while the block is idle
    task automatic write_select(input logic [SEL_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [SEL_W-1:0] pick;
        int               set_size;
        int               big_sets;

        big_sets = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset count of 64: field extremes, a three-way tie kept in load order
        add_record(16'h0000, 8'd0,   8'd0,   8'd0,   1'b0);
        add_record(16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b0);
        add_record(16'h1234, 8'd100, 8'd100, 8'd100, 1'b0);
        add_record(16'hA5A5, 8'd50,  8'd150, 8'd100, 1'b0);
        add_record(16'h5A5A, 8'd255, 8'd45,  8'd0,   1'b0);
        add_record(16'h0F0F, 8'd1,   8'd0,   8'd0,   1'b1);
        settle();

        // Count of zero: nothing emitted, store still emptied
        write_select(7'd0);
        add_record(16'h1111, 8'd10, 8'd20, 8'd30, 1'b0);
        add_record(16'h2222, 8'd40, 8'd50, 8'd60, 1'b0);
        add_record(16'h3333, 8'd70, 8'd80, 8'd90, 1'b1);
        settle();

        // Cut inside a run of ties: the rest of the run follows as extra list
        write_select(7'd2);
        add_record(16'h0001, 8'd200, 8'd200, 8'd100, 1'b0);
        add_record(16'h0002, 8'd100, 8'd100, 8'd100, 1'b0);
        add_record(16'h0003, 8'd0,   8'd150, 8'd150, 1'b0);
        add_record(16'h0004, 8'd255, 8'd45,  8'd0,   1'b0);
        add_record(16'h0005, 8'd100, 8'd50,  8'd50,  1'b1);
        settle();

        // Count above the records held: clamp
        write_select(7'h7F);
        add_record(16'hBEEF, 8'd9, 8'd8, 8'd7, 1'b0);
        add_record(16'hCAFE, 8'd7, 8'd8, 8'd9, 1'b0);
        add_record(16'h8000, 8'd3, 8'd2, 8'd1, 1'b1);
        settle();

        // Count of one over all-equal totals
        write_select(7'd1);
        add_record(16'h7FFF, 8'd255, 8'd0,   8'd0,   1'b0);
        add_record(16'h00FF, 8'd0,   8'd255, 8'd0,   1'b0);
        add_record(16'hFF00, 8'd0,   8'd0,   8'd255, 1'b0);
        add_record(16'h5555, 8'd85,  8'd85,  8'd85,  1'b1);
        settle();

        // Single-record set at the reset count
        write_select(SEL_RESET);
        add_record(16'hAAAA, 8'd255, 8'd255, 8'd255, 1'b1);
        settle();

        // Pressure: hold the result side off while two sets are offered back
        // to back, so the sorter stalls its input during the first emission
        long_hold = LONG_HOLD;
        add_random_set(5, 1'b1);
        add_random_set(6, 1'b0);
        settle();

        // Random sets, with the configuration changed between them
        while (queued_n < ITEM_TARGET) begin
            if (queued_n >= ITEM_TARGET - TAIL_ITEMS)
                calm_tail = 1'b1;

            if (big_sets < 2 && (queued_n > 150 || $urandom_range(0, 7) == 0)) begin
                // Overfill the store; the first overfill runs at the full count
                if (big_sets == 0)
                    write_select(SEL_RESET);
                set_size = STORE_DEPTH + 1 + big_sets;
                big_sets++;
            end else begin
                if ($urandom_range(0, 1)) begin
                    case ($urandom_range(0, 5))
                        0:       pick = 7'd0;
                        1:       pick = 7'd1;
                        2:       pick = SEL_RESET;
                        3:       pick = 7'h7F;
                        4:       pick = SEL_W'($urandom_range(0, 127));
                        default: pick = SEL_W'($urandom_range(1, 8));
                    endcase
                    write_select(pick);
                end
                set_size = $urandom_range(1, 10);
            end

            add_random_set(set_size, $urandom_range(0, 1));
            settle();
        end

        settle();
        stimulus_done = 1'b1;

        if (mismatch_count == 0 && expected_ranking.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
